>>> src/rrqs_pkg.sv
// Shared types and constants for the round-robin quantum scheduler.
// No dependencies; the scheduler, checker and testbench refer to it by scoped names.
package rrqs_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam logic [15:0] QUANTUM_RST     = 16'd4;
	localparam logic [39:0] SUM_MAX         = 40'hFF_FFFF_FFFF;
	localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

	typedef enum logic {
		REQ_ADD = 1'b0,
		REQ_RUN = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  job_id;
		logic [31:0] ready_time;
		logic [15:0] burst_length;
	} job_req_t;

	typedef struct packed {
		logic [7:0]  ran_id;
		logic [15:0] run_length;
		logic        job_done;
		logic [31:0] now_time;
		logic [39:0] wait_total;
		logic [39:0] turnaround_total;
		logic [15:0] done_count;
		logic        queue_empty;
	} sched_res_t;

	// one queue slot: id, remaining burst, ready time (56 bits)
	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] burst;
		logic [31:0] ready;
	} queue_entry_t;

	localparam int unsigned ENTRY_W = $bits(queue_entry_t);

endpackage

>>> src/rrqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// No dependencies.
module rrqs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/round_robin_quantum_scheduler.sv
// Round-robin time-quantum scheduler, top level.
// Depends on rrqs_pkg and rrqs_ram.
//
// Usage:
//   job channel (job_valid/job_stall, payload job): an add request appends a
//   job to the FIFO (dropped when full); a run request pops the head job,
//   runs it for at most one quantum and requeues it if unfinished.
//   res channel (res_valid/res_stall, payload res): one result per run
//   request, none per add request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the quantum; always
//   ready, and a quantum of 0 acts as 1.
// Flow: a request is registered on transfer into the input register and
// processed from there; a run request's result is then registered in the
// result register, which raises res_valid.
// Throughput: one request per cycle unless a run request waits on a stalled
// result. The head job sits in a register and the next one is prefetched from
// the queue RAM every cycle, so back-to-back runs and requeues do not stall.
// Stall: while res_stall holds a result, a pending run request waits in the
// input register and job_stall rises; add requests still go through.
// Reset (arst_n low): queue empty, time, totals and count zero, quantum 4.
// No clearing pass is needed; queue RAM contents are only read once written.
module round_robin_quantum_scheduler #(
	parameter int unsigned QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_stall,
	input  rrqs_pkg::job_req_t  job,
	output logic                res_valid,
	input  logic                res_stall,
	output rrqs_pkg::sched_res_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

	// input register
	rrqs_pkg::job_req_t   job_s1;
	logic                 s1_valid_q;

	// queue
	rrqs_pkg::queue_entry_t head_q, head_d;
	rrqs_pkg::queue_entry_t byp_data_q, nxt_entry, push_entry;
	logic                   byp_sel_q;
	logic [OCC_W-1:0]       occ_q, occ_d, occ_after_pop;
	logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
	logic                   ram_we;
	logic [rrqs_pkg::ENTRY_W-1:0] ram_rdata;

	// scheduler state
	logic [15:0] quantum_q, q_eff;
	logic [31:0] clock_q, clock_d, clock_new, wait_amt;
	logic [39:0] wsum_q, wsum_d, tsum_q, tsum_d;
	logic [40:0] wsum_ext, tsum_ext;
	logic [15:0] fin_q, fin_d, granted;
	logic        fits, is_run, is_empty, pop, push;

	// handshake
	logic                 out_ready, proc_go;
	rrqs_pkg::sched_res_t res_q, res_d;
	logic                 res_valid_q;

	assign out_ready = !res_valid_q || !res_stall;
	assign is_run    = (job_s1.req_type == rrqs_pkg::REQ_RUN);
	assign proc_go   = s1_valid_q && (!is_run || out_ready);
	assign job_stall = s1_valid_q && !proc_go;
	assign cfg_ready = 1'b1;

	assign nxt_entry = byp_sel_q ? byp_data_q : rrqs_pkg::queue_entry_t'(ram_rdata);

	// slice arithmetic on the head job
	always_comb begin
		q_eff     = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
		wait_amt  = (clock_q > head_q.ready) ? (clock_q - head_q.ready) : 32'd0;
		wsum_ext  = {1'b0, wsum_q} + {9'd0, wait_amt};
		fits      = (head_q.burst <= q_eff);
		granted   = fits ? head_q.burst : q_eff;
		clock_new = clock_q + {16'd0, granted};
		tsum_ext  = {1'b0, tsum_q} + {9'd0, clock_new};
	end

	// queue and state update
	always_comb begin
		is_empty      = (occ_q == '0);
		pop           = proc_go && is_run && !is_empty;
		push          = proc_go && ((!is_run && occ_q != OCC_W'(QUEUE_DEPTH))
			|| (is_run && !is_empty && !fits));
		push_entry    = is_run ? rrqs_pkg::queue_entry_t'({head_q.id,
			16'(head_q.burst - q_eff), clock_new})
			: rrqs_pkg::queue_entry_t'({job_s1.job_id, job_s1.burst_length,
			job_s1.ready_time});
		occ_after_pop = occ_q - OCC_W'(pop);

		head_d   = head_q;
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		ram_we   = 1'b0;

		if (pop && occ_after_pop != '0) begin
			head_d   = nxt_entry;
			rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
		if (push) begin
			if (occ_after_pop == '0) begin
				head_d = push_entry;
			end else begin
				ram_we   = 1'b1;
				wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
		end
		occ_d = occ_after_pop + OCC_W'(push);

		clock_d = clock_q;
		wsum_d  = wsum_q;
		tsum_d  = tsum_q;
		fin_d   = fin_q;
		if (pop) begin
			clock_d = clock_new;
			wsum_d  = wsum_ext[40] ? rrqs_pkg::SUM_MAX : wsum_ext[39:0];
			if (fits) begin
				tsum_d = tsum_ext[40] ? rrqs_pkg::SUM_MAX : tsum_ext[39:0];
				fin_d  = (fin_q == rrqs_pkg::COUNT_MAX) ? fin_q : fin_q + 16'd1;
			end
		end

		res_d.ran_id           = is_empty ? 8'd0 : head_q.id;
		res_d.run_length       = is_empty ? 16'd0 : granted;
		res_d.job_done         = !is_empty && fits;
		res_d.now_time         = clock_d;
		res_d.wait_total       = wsum_d;
		res_d.turnaround_total = tsum_d;
		res_d.done_count       = fin_d;
		res_d.queue_empty      = is_empty;
	end

	rrqs_ram #(
		.WIDTH(rrqs_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wr_ptr_q),
		.wr_data(push_entry),
		.rd_addr(rd_ptr_d),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			occ_q       <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			byp_sel_q   <= 1'b0;
			clock_q     <= '0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			fin_q       <= '0;
			quantum_q   <= rrqs_pkg::QUANTUM_RST;
		end else begin
			if (job_valid && !job_stall) begin
				s1_valid_q <= 1'b1;
			end else if (proc_go) begin
				s1_valid_q <= 1'b0;
			end
			if (out_ready) begin
				res_valid_q <= proc_go && is_run;
			end
			occ_q     <= occ_d;
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			// a write landing on the slot being prefetched is caught here
			byp_sel_q <= ram_we && (wr_ptr_q == rd_ptr_d);
			clock_q   <= clock_d;
			wsum_q    <= wsum_d;
			tsum_q    <= tsum_d;
			fin_q     <= fin_d;
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && !job_stall) begin
			job_s1 <= job;
		end
		head_q     <= head_d;
		byp_data_q <= push_entry;
		if (out_ready && proc_go && is_run) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> src/rrqs_checker.sv
// Port-level checks for the round-robin quantum scheduler, bound to the top.
// Depends on rrqs_pkg.
module rrqs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_stall,
	input rrqs_pkg::sched_res_t res
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// an empty-queue result carries no job
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.queue_empty |->
			res.ran_id == 8'd0 && res.run_length == 16'd0 && !res.job_done)
		else $error("empty-queue result carries a job");

	// a requeued job always gets a non-zero slice
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.queue_empty && !res.job_done |-> res.run_length != 16'd0)
		else $error("requeued job granted zero time");

	// finishing a job bumps or saturates the count
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.job_done |-> res.done_count != 16'd0)
		else $error("finished job with zero done count");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

>>> tb/round_robin_quantum_scheduler_tb.sv
// Self-checking testbench for round_robin_quantum_scheduler: directed and random
// job requests, checked per result against an in-bench model of the FIFO and totals.
// Depends on rrqs_pkg and the scheduler RTL only.
module round_robin_quantum_scheduler_tb;

	localparam int unsigned DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTING_ITEMS = 70;
	localparam int WRAP_PAIRS    = 20;

	class slice_tracker;
		rrqs_pkg::queue_entry_t job_fifo[$];
		rrqs_pkg::sched_res_t   pending_slices[$];
		logic [15:0]  quantum   = rrqs_pkg::QUANTUM_RST;
		logic [31:0]  clock_now = '0;
		logic [39:0]  wait_sum  = '0;
		logic [39:0]  turn_sum  = '0;
		logic [15:0]  finished  = '0;
		int requests, slices, completions, empties, dropped, wraps, errors;

		function logic [39:0] sat_sum(logic [39:0] a, logic [39:0] b);
			logic [40:0] s;
			s = {1'b0, a} + {1'b0, b};
			return (s > {1'b0, rrqs_pkg::SUM_MAX}) ? rrqs_pkg::SUM_MAX : s[39:0];
		endfunction

		function void advance(logic [15:0] d);
			logic [32:0] t;
			t = {1'b0, clock_now} + {17'b0, d};
			if (t[32])
				wraps++;
			clock_now = t[31:0];
		endfunction

		function void note_request(rrqs_pkg::job_req_t r);
			rrqs_pkg::queue_entry_t e;
			rrqs_pkg::sched_res_t   s;
			logic [15:0]  q;
			logic [31:0]  w;
			requests++;
			if (r.req_type == rrqs_pkg::REQ_ADD) begin
				if (job_fifo.size() >= DEPTH) begin
					dropped++;
				end else begin
					e.id    = r.job_id;
					e.burst = r.burst_length;
					e.ready = r.ready_time;
					job_fifo.insert(job_fifo.size(), e);
				end
				return;
			end
			s = '0;
			slices++;
			if (job_fifo.size() == 0) begin
				empties++;
				s.queue_empty = 1'b1;
			end else begin
				e = job_fifo.pop_front();
				if (clock_now > e.ready) begin
					w = clock_now - e.ready;
					wait_sum = sat_sum(wait_sum, {8'b0, w});
				end
				q = (quantum == 16'd0) ? 16'd1 : quantum;
				s.ran_id = e.id;
				if (e.burst <= q) begin
					s.run_length = e.burst;
					s.job_done   = 1'b1;
					advance(e.burst);
					turn_sum = sat_sum(turn_sum, {8'b0, clock_now});
					if (finished != rrqs_pkg::COUNT_MAX)
						finished++;
					completions++;
				end else begin
					s.run_length = q;
					advance(q);
					e.burst = e.burst - q;
					e.ready = clock_now;
					job_fifo.insert(job_fifo.size(), e);
				end
			end
			s.now_time         = clock_now;
			s.wait_total       = wait_sum;
			s.turnaround_total = turn_sum;
			s.done_count       = finished;
			pending_slices.insert(pending_slices.size(), s);
		endfunction

		function bit same(string f, logic [39:0] want, logic [39:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h got %0h", $time, f, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_slice(rrqs_pkg::sched_res_t got);
			rrqs_pkg::sched_res_t want;
			bit ok;
			if (pending_slices.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none got %h", $time, got);
				return;
			end
			want = pending_slices.pop_front();
			ok = same("ran_id", 40'(want.ran_id), 40'(got.ran_id))
				& same("run_length", 40'(want.run_length), 40'(got.run_length))
				& same("job_done", 40'(want.job_done), 40'(got.job_done))
				& same("now_time", 40'(want.now_time), 40'(got.now_time))
				& same("wait_total", want.wait_total, got.wait_total)
				& same("turnaround_total", want.turnaround_total, got.turnaround_total)
				& same("done_count", 40'(want.done_count), 40'(got.done_count))
				& same("queue_empty", 40'(want.queue_empty), 40'(got.queue_empty));
			if (!ok)
				errors++;
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        job_valid = 1'b0;
	logic        job_stall;
	rrqs_pkg::job_req_t    job = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	rrqs_pkg::sched_res_t  res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	slice_tracker sb;
	int src_idle  = 13;
	int snk_idle  = 73;
	int hold_left = 0;
	int quiet     = 0;

	round_robin_quantum_scheduler #(.QUEUE_DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_stall (job_stall),
		.job       (job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function rrqs_pkg::job_req_t make_add(logic [7:0] id, logic [31:0] ready,
		logic [15:0] burst);
		rrqs_pkg::job_req_t r;
		r.req_type     = rrqs_pkg::REQ_ADD;
		r.job_id       = id;
		r.ready_time   = ready;
		r.burst_length = burst;
		return r;
	endfunction

	function rrqs_pkg::job_req_t random_request();
		rrqs_pkg::job_req_t r;
		int q;
		int cap;
		q   = (sb.quantum == 16'd0) ? 1 : int'(sb.quantum);
		cap = (3 * q > 65535) ? 65535 : 3 * q;
		r.req_type = ($urandom_range(99) < 48) ? rrqs_pkg::REQ_RUN : rrqs_pkg::REQ_ADD;
		r.job_id   = 8'($urandom_range(255));
		case ($urandom_range(9))
			0: r.burst_length = 16'd0;
			1, 2: r.burst_length = 16'($urandom);
			default: r.burst_length = 16'($urandom_range(cap, 1));
		endcase
		if ($urandom_range(1))
			r.ready_time = sb.clock_now + 32'($urandom_range(64)) - 32'd32;
		else
			r.ready_time = $urandom;
		return r;
	endfunction

	task automatic drive_job(input rrqs_pkg::job_req_t r);
		while ($urandom_range(99) < src_idle) begin
			job_valid <= 1'b0;
			@(posedge clk);
		end
		job_valid <= 1'b1;
		job       <= r;
		do @(posedge clk); while (job_stall);
		sb.note_request(r);
	endtask

	task automatic flood_adds();
		repeat (DEPTH + 2)
			drive_job(make_add(8'($urandom_range(255)), $urandom,
				16'($urandom_range(65535, 1))));
	endtask

	task automatic write_quantum(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.quantum = v;
	endtask

	task automatic settle();
		job_valid <= 1'b0;
		while (sb.pending_slices.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: random stall, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < snk_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_slice(res);
	end

	always @(posedge clk) begin
		if ((job_valid && !job_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		rrqs_pkg::job_req_t r;
		logic [15:0] settings[6];
		int          k;
		int          n;
		sb = new();
		settings = '{16'd1, 16'd0, 16'd7, 16'hFFFF, 16'($urandom_range(4000, 8)),
			rrqs_pkg::QUANTUM_RST};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// run on an empty queue, field extremes, zero burst, exact quantum, full queue
		r = '0;
		r.req_type = rrqs_pkg::REQ_RUN;
		drive_job(r);
		drive_job(make_add(8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
		drive_job(make_add(8'h00, 32'h0, 16'h0));
		drive_job(make_add(8'h01, 32'h0, 16'd4));
		drive_job(make_add(8'h02, 32'h0, 16'd5));
		for (n = 0; n < 14; n++)
			drive_job(make_add(8'(n + 3), 32'($urandom_range(20)), 16'($urandom_range(9, 1))));
		for (n = 0; n < 6; n++) begin
			r = random_request();
			r.req_type = rrqs_pkg::REQ_RUN;
			drive_job(r);
		end
		settle();

		for (k = 0; k < 6; k++) begin
			src_idle = (k < 2) ? 13 : (k < 4) ? 73 : 0;
			snk_idle = (k < 2) ? 73 : (k < 4) ? 13 : 0;
			write_quantum(settings[k]);
			for (n = 0; n < SETTING_ITEMS; n++) begin
				if (n == 0 && (k == 0 || k == 3))
					hold_left = 120;
				if ($urandom_range(24) == 0) begin
					flood_adds();
					n += DEPTH + 1;
				end else begin
					drive_job(random_request());
				end
			end
			settle();
		end

		// full-quantum sweep with maximum bursts and far-off ready times
		write_quantum(16'hFFFF);
		r = '0;
		r.req_type = rrqs_pkg::REQ_RUN;
		for (n = 0; n < WRAP_PAIRS; n++) begin
			drive_job(make_add(8'(n), (n % 2) ? $urandom : 32'h0, 16'hFFFF));
			drive_job(r);
		end
		for (n = 0; n < 60; n++)
			drive_job(random_request());
		settle();
		repeat (8) @(posedge clk);

		$display("Ran %0d requests: %0d slices, %0d completions, %0d empty runs, %0d drops",
			sb.requests, sb.slices, sb.completions, sb.empties, sb.dropped);
		$display("Quantum settings 1, 0, 7, 65535, %0d and 4; time wrapped %0d time(s)",
			settings[4], sb.wraps);
		if (sb.errors == 0 && sb.pending_slices.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
src/rrqs_pkg.sv
src/rrqs_ram.sv
src/round_robin_quantum_scheduler.sv
src/rrqs_checker.sv
tb/round_robin_quantum_scheduler_tb.sv
